[hdl/assert_macros.svh]
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("assertion failed");

// consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

[hdl/hrhp_pkg.sv]
`default_nettype none
package hrhp_pkg;

	// phase codes
	localparam logic [2:0] PH_METHOD = 3'd0;
	localparam logic [2:0] PH_URL    = 3'd1;
	localparam logic [2:0] PH_VER    = 3'd2;
	localparam logic [2:0] PH_HNAME  = 3'd3;
	localparam logic [2:0] PH_HVAL   = 3'd4;
	localparam logic [2:0] PH_DONE   = 3'd5;

	// field kinds
	localparam logic [2:0] KIND_METHOD = 3'd0;
	localparam logic [2:0] KIND_URL    = 3'd1;
	localparam logic [2:0] KIND_VER    = 3'd2;
	localparam logic [2:0] KIND_HNAME  = 3'd3;
	localparam logic [2:0] KIND_HVAL   = 3'd4;

	// verdicts
	localparam logic [2:0] VD_BUSY    = 3'd0;
	localparam logic [2:0] VD_GET     = 3'd1;
	localparam logic [2:0] VD_POST    = 3'd2;
	localparam logic [2:0] VD_BAD     = 3'd3;
	localparam logic [2:0] VD_NOT_ALW = 3'd4;
	localparam logic [2:0] VD_DROP    = 3'd5;

	// commands
	localparam logic CMD_BYTE  = 1'b0;
	localparam logic CMD_START = 1'b1;

	// escape steps
	localparam logic [1:0] ESC_NONE = 2'd0;
	localparam logic [1:0] ESC_PCT  = 2'd1;
	localparam logic [1:0] ESC_HI   = 2'd2;

	// config register indexes
	localparam logic CFG_MAX_LINE = 1'b0;
	localparam logic CFG_MAX_HDR  = 1'b1;

	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_COLON = 8'h3A;

	localparam logic [15:0] MAX_LINE_RST = 16'd2048;
	localparam logic [7:0]  MAX_HDR_RST  = 8'd32;

	typedef struct packed {
		logic       get_alive;
		logic       post_alive;
		logic [2:0] len;
	} method_match_t;

	localparam method_match_t MM_RST = '{get_alive: 1'b1, post_alive: 1'b1, len: 3'd0};

	// hex digit decode, bit 4 set when the byte is a hex digit
	function automatic logic [4:0] hex_nibble(input logic [7:0] b);
		logic [4:0] r;
		r = 5'd0;
		if (b >= 8'h30 && b <= 8'h39) r = {1'b1, b[3:0]};
		else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46))
			r = {1'b1, b[3:0] + 4'd9};
		return r;
	endfunction

	function automatic logic [7:0] get_char(input logic [2:0] idx);
		logic [7:0] c;
		unique case (idx)
			3'd0: c = 8'h67;
			3'd1: c = 8'h65;
			3'd2: c = 8'h74;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] post_char(input logic [2:0] idx);
		logic [7:0] c;
		unique case (idx)
			3'd0: c = 8'h70;
			3'd1: c = 8'h6F;
			3'd2: c = 8'h73;
			3'd3: c = 8'h74;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic method_match_t match_step(input method_match_t m, input logic [7:0] b);
		method_match_t r;
		logic [7:0] lb;
		lb = (b >= 8'h41 && b <= 8'h5A) ? b + 8'h20 : b;
		r.get_alive  = m.get_alive  && (m.len < 3'd3) && (get_char(m.len) == lb);
		r.post_alive = m.post_alive && (m.len < 3'd4) && (post_char(m.len) == lb);
		r.len        = (m.len < 3'd5) ? m.len + 3'd1 : m.len;
		return r;
	endfunction

	function automatic logic [2:0] method_verdict(input method_match_t m);
		logic [2:0] v;
		if (m.get_alive && m.len == 3'd3) v = VD_GET;
		else if (m.post_alive && m.len == 3'd4) v = VD_POST;
		else v = VD_NOT_ALW;
		return v;
	endfunction

endpackage
`default_nettype wire

[hdl/http_request_head_parser.sv]
`default_nettype none
// channel   dir  width            contents
// s_axis    in   tdata 8, tuser 1 received byte, command (1 = start new request)
// m_axis    out  tdata 16, tuser 3 byte_valid/out_byte/field_end/verdict, field_kind
// cfg       in   index 1, data 16 0 max_line_length, 1 max_header_lines
//
// one word per cycle unless m_axis stalls; path: input register, then result register
// while a result waits the input register takes one more word, then s_tready
// drops until m_axis accepts; a stall on m_axis backs up through both
// arst_n clears the parser state, valid flags and config registers to their defaults
// configuration takes effect for the next word processed
module http_request_head_parser (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
	input  wire logic        s_tuser,   // [0] command
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,   // [0] byte_valid, [8:1] out_byte, [9] field_end,
	                                    // [12:10] verdict, [15:13] zero
	output logic [2:0]       m_tuser,   // [2:0] field_kind
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [15:0] cfg_data
);
	import hrhp_pkg::*;

	// configuration registers
	logic [15:0] max_line_q;
	logic [7:0]  max_hdr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_line_q <= MAX_LINE_RST;
			max_hdr_q  <= MAX_HDR_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MAX_LINE: max_line_q <= cfg_data;
				CFG_MAX_HDR:  max_hdr_q  <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// input register
	logic       valid_s1;
	logic       cmd_s1;
	logic [7:0] byte_s1;
	logic       advance;

	assign advance  = valid_s1 && (!m_tvalid || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_s1  <= s_tuser;
			byte_s1 <= s_tdata;
		end
	end

	// parser state
	logic [2:0]    phase_q;
	logic          cr_pend_q;
	logic [15:0]   line_cnt_q;
	logic [7:0]    hdr_lines_q;
	logic [1:0]    esc_q;
	logic [3:0]    esc_hi_q;
	logic          line_err_q;
	method_match_t mm_q;
	logic [1:0]    skip_q;
	logic [2:0]    verdict_q;

	logic [2:0]    phase_d;
	logic          cr_pend_d;
	logic [15:0]   line_cnt_d;
	logic [7:0]    hdr_lines_d;
	logic [1:0]    esc_d;
	logic [3:0]    esc_hi_d;
	logic          line_err_d;
	method_match_t mm_d;
	logic [1:0]    skip_d;
	logic [2:0]    verdict_d;

	logic          valid_d;
	logic [7:0]    obyte_d;
	logic [2:0]    kind_d;
	logic          fend_d;

	logic [16:0]   line_next;
	logic [4:0]    hex;

	assign line_next = {1'b0, line_cnt_q} + 17'd1;
	assign hex       = hex_nibble(byte_s1);

	// one step of the request parser per word
	always_comb begin
		phase_d     = phase_q;
		cr_pend_d   = cr_pend_q;
		line_cnt_d  = line_cnt_q;
		hdr_lines_d = hdr_lines_q;
		esc_d       = esc_q;
		esc_hi_d    = esc_hi_q;
		line_err_d  = line_err_q;
		mm_d        = mm_q;
		skip_d      = skip_q;
		verdict_d   = verdict_q;
		valid_d     = 1'b0;
		obyte_d     = 8'd0;
		kind_d      = KIND_METHOD;
		fend_d      = 1'b0;

		if (cmd_s1 == CMD_START) begin
			phase_d     = PH_METHOD;
			cr_pend_d   = 1'b0;
			line_cnt_d  = 16'd0;
			hdr_lines_d = 8'd0;
			esc_d       = ESC_NONE;
			esc_hi_d    = 4'd0;
			line_err_d  = 1'b0;
			mm_d        = MM_RST;
			skip_d      = 2'd0;
			verdict_d   = VD_BUSY;
		end else if (phase_q >= PH_DONE) begin
			// finished, ignore until a new request
		end else if (cr_pend_q) begin
			// line end or bare CR
			cr_pend_d = 1'b0;
			if (byte_s1 != CH_LF) begin
				verdict_d = VD_DROP;
				phase_d   = PH_DONE;
			end else if (phase_q <= PH_VER) begin
				if (phase_q == PH_VER) begin
					fend_d = 1'b1;
					kind_d = KIND_VER;
				end
				if (phase_q != PH_VER || line_err_q) begin
					verdict_d = VD_BAD;
					phase_d   = PH_DONE;
				end else begin
					phase_d = PH_HNAME;
				end
			end else if (phase_q == PH_HNAME) begin
				// blank line ends the head, anything else lacks its colon
				verdict_d = (line_cnt_q == 16'd0) ? method_verdict(mm_q) : VD_BAD;
				phase_d   = PH_DONE;
			end else begin
				fend_d = 1'b1;
				kind_d = KIND_HVAL;
				if (hdr_lines_q >= max_hdr_q) begin
					verdict_d = VD_BAD;
					phase_d   = PH_DONE;
				end else begin
					hdr_lines_d = hdr_lines_q + 8'd1;
					phase_d     = PH_HNAME;
				end
			end
			line_cnt_d = 16'd0;
			esc_d      = ESC_NONE;
			line_err_d = 1'b0;
			skip_d     = 2'd0;
		end else if (byte_s1 == CH_CR) begin
			cr_pend_d = 1'b1;
		end else if (line_next >= {1'b0, max_line_q}) begin
			// line would overflow the buffer
			verdict_d = VD_DROP;
			phase_d   = PH_DONE;
		end else begin
			line_cnt_d = line_next[15:0];
			unique case (phase_q)
				PH_METHOD: begin
					if (byte_s1 == CH_SP) begin
						fend_d  = 1'b1;
						kind_d  = KIND_METHOD;
						phase_d = PH_URL;
					end else begin
						mm_d    = match_step(mm_q, byte_s1);
						valid_d = 1'b1;
						obyte_d = byte_s1;
						kind_d  = KIND_METHOD;
					end
				end
				PH_URL: begin
					if (byte_s1 == CH_SP) begin
						if (esc_q != ESC_NONE) line_err_d = 1'b1;
						esc_d   = ESC_NONE;
						fend_d  = 1'b1;
						kind_d  = KIND_URL;
						phase_d = PH_VER;
					end else if (esc_q == ESC_PCT) begin
						if (!hex[4]) begin
							line_err_d = 1'b1;
							esc_d      = ESC_NONE;
						end else begin
							esc_hi_d = hex[3:0];
							esc_d    = ESC_HI;
						end
					end else if (esc_q == ESC_HI) begin
						if (!hex[4]) begin
							line_err_d = 1'b1;
						end else begin
							valid_d = 1'b1;
							kind_d  = KIND_URL;
							obyte_d = {esc_hi_q, hex[3:0]};
						end
						esc_d = ESC_NONE;
					end else if (byte_s1 == CH_PCT) begin
						esc_d = ESC_PCT;
					end else begin
						esc_d   = ESC_NONE;
						valid_d = 1'b1;
						obyte_d = byte_s1;
						kind_d  = KIND_URL;
					end
				end
				PH_VER: begin
					valid_d = 1'b1;
					obyte_d = byte_s1;
					kind_d  = KIND_VER;
				end
				PH_HNAME: begin
					if (byte_s1 == CH_COLON) begin
						fend_d  = 1'b1;
						kind_d  = KIND_HNAME;
						phase_d = PH_HVAL;
						skip_d  = 2'd2;
					end else begin
						valid_d = 1'b1;
						obyte_d = byte_s1;
						kind_d  = KIND_HNAME;
					end
				end
				default: begin
					// header value, after the two skipped bytes
					if (skip_q != 2'd0) begin
						skip_d = skip_q - 2'd1;
					end else begin
						valid_d = 1'b1;
						obyte_d = byte_s1;
						kind_d  = KIND_HVAL;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_METHOD;
			cr_pend_q   <= 1'b0;
			line_cnt_q  <= 16'd0;
			hdr_lines_q <= 8'd0;
			esc_q       <= ESC_NONE;
			esc_hi_q    <= 4'd0;
			line_err_q  <= 1'b0;
			mm_q        <= MM_RST;
			skip_q      <= 2'd0;
			verdict_q   <= VD_BUSY;
		end else if (advance) begin
			phase_q     <= phase_d;
			cr_pend_q   <= cr_pend_d;
			line_cnt_q  <= line_cnt_d;
			hdr_lines_q <= hdr_lines_d;
			esc_q       <= esc_d;
			esc_hi_q    <= esc_hi_d;
			line_err_q  <= line_err_d;
			mm_q        <= mm_d;
			skip_q      <= skip_d;
			verdict_q   <= verdict_d;
		end
	end

	// result register
	logic       out_valid_q;
	logic       bvalid_q;
	logic [7:0] obyte_q;
	logic [2:0] kind_q;
	logic       fend_q;
	logic [2:0] vd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			bvalid_q <= valid_d;
			obyte_q  <= obyte_d;
			kind_q   <= kind_d;
			fend_q   <= fend_d;
			vd_q     <= verdict_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'd0, vd_q, fend_q, obyte_q, bvalid_q};
	assign m_tuser  = kind_q;

endmodule
`default_nettype wire

[hdl/hrhp_checker.sv]
`default_nettype none
`include "assert_macros.svh"
module hrhp_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [15:0] m_tdata,
	input wire logic [2:0]  m_tuser
);
	import hrhp_pkg::*;

	// a stalled result stays put
	`ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
	// a word is never both a content byte and a field end
	`ASSERT_IMPLIES(a_byte_xor_end, clk, arst_n, m_tvalid, !(m_tdata[0] && m_tdata[9]))
	// no content byte without byte_valid
	`ASSERT_IMPLIES(a_byte_zero, clk, arst_n, m_tvalid && !m_tdata[0], m_tdata[8:1] == 8'd0)
	// field kind stays zero when no field is touched; verdict in range, top bits zero
	`ASSERT_IMPLIES(a_kind_idle, clk, arst_n, m_tvalid && !m_tdata[0] && !m_tdata[9],
		m_tuser == KIND_METHOD)
	`ASSERT_IMPLIES(a_verdict_range, clk, arst_n, m_tvalid,
		m_tdata[12:10] <= VD_DROP && m_tdata[15:13] == 3'd0)

endmodule

bind http_request_head_parser hrhp_checker u_hrhp_checker (.*);
`default_nettype wire

[tb/sv/tb.sv]
`timescale 1ns / 100ps

module tb;
	import hrhp_pkg::*;

	// one result word of the parser split into its fields
	typedef struct packed {
		logic       byte_valid;
		logic [7:0] out_byte;
		logic [2:0] field_kind;
		logic       field_end;
		logic [2:0] verdict;
	} head_out_t;

	// one input word: command plus received byte
	typedef struct packed {
		logic       command;
		logic [7:0] data_byte;
	} head_in_t;

	localparam int IdleLimit  = 4000;  // cycles with no word moving on either side
	localparam int HoldCycles = 300;   // long receiver hold-off

	// parser model plus the queue of field words still owed by the block
	class parse_scoreboard;
		logic [15:0] max_line;
		logic [7:0]  max_hdr;

		logic [2:0]  phase;
		bit          cr_seen;
		int unsigned line_len;
		logic [7:0]  hdr_count;
		logic [1:0]  esc;
		logic [3:0]  esc_hi;
		bit          line_bad;
		bit          get_ok;
		bit          post_ok;
		int          mlen;
		int          skip;
		logic [2:0]  verdict;

		string       get_lc = "get";
		string       post_lc = "post";
		head_out_t   fields_due[$];
		int          errors;

		function new();
			max_line = MAX_LINE_RST;
			max_hdr = MAX_HDR_RST;
			errors = 0;
			restart();
		endfunction

		function void restart();
			phase = PH_METHOD;
			cr_seen = 1'b0;
			line_len = 0;
			hdr_count = '0;
			esc = ESC_NONE;
			esc_hi = '0;
			line_bad = 1'b0;
			get_ok = 1'b1;
			post_ok = 1'b1;
			mlen = 0;
			skip = 0;
			verdict = VD_BUSY;
		endfunction

		// -1 when the byte is not a hex digit
		static function int hex_value(logic [7:0] b);
			if (b >= 8'h30 && b <= 8'h39) return int'(b - 8'h30);
			if (b >= 8'h61 && b <= 8'h66) return b - 8'h61 + 10;
			if (b >= 8'h41 && b <= 8'h46) return b - 8'h41 + 10;
			return -1;
		endfunction

		function void write_reg(logic index, logic [15:0] value);
			if (index == CFG_MAX_LINE) max_line = value;
			else max_hdr = value[7:0];
		endfunction

		// advance the parser by one accepted word and queue the field word it yields
		function void note_byte(logic cmd, logic [7:0] b);
			head_out_t r;
			logic [7:0] lc;
			int nib;
			r = '0;
			if (cmd == CMD_START) begin
				restart();
			end else if (phase == PH_DONE) begin
				// verdict reached, bytes ignored until the next start
			end else if (cr_seen) begin
				cr_seen = 1'b0;
				if (b != CH_LF) begin
					verdict = VD_DROP;
					phase = PH_DONE;
				end else if (phase <= PH_VER) begin
					if (phase == PH_VER) begin
						r.field_end = 1'b1;
						r.field_kind = KIND_VER;
					end
					if (phase != PH_VER || line_bad) begin
						verdict = VD_BAD;
						phase = PH_DONE;
					end else begin
						phase = PH_HNAME;
					end
				end else if (phase == PH_HNAME) begin
					// blank line ends the head, a non-blank one lacked its colon
					if (line_len != 0) verdict = VD_BAD;
					else if (get_ok && mlen == 3) verdict = VD_GET;
					else if (post_ok && mlen == 4) verdict = VD_POST;
					else verdict = VD_NOT_ALW;
					phase = PH_DONE;
				end else begin
					r.field_end = 1'b1;
					r.field_kind = KIND_HVAL;
					if (hdr_count >= max_hdr) begin
						verdict = VD_BAD;
						phase = PH_DONE;
					end else begin
						hdr_count++;
						phase = PH_HNAME;
					end
				end
				line_len = 0;
				esc = ESC_NONE;
				line_bad = 1'b0;
				skip = 0;
			end else if (b == CH_CR) begin
				cr_seen = 1'b1;
			end else if (line_len + 1 >= max_line) begin
				verdict = VD_DROP;
				phase = PH_DONE;
			end else begin
				line_len++;
				case (phase)
					PH_METHOD: begin
						if (b == CH_SP) begin
							r.field_end = 1'b1;
							r.field_kind = KIND_METHOD;
							phase = PH_URL;
						end else begin
							// case-blind match against get and post
							lc = (b >= 8'h41 && b <= 8'h5A) ? b + 8'h20 : b;
							if (mlen >= 3 || lc != get_lc[mlen]) get_ok = 1'b0;
							if (mlen >= 4 || lc != post_lc[mlen]) post_ok = 1'b0;
							if (mlen < 5) mlen++;
							r.byte_valid = 1'b1;
							r.out_byte = b;
							r.field_kind = KIND_METHOD;
						end
					end
					PH_URL: begin
						if (b == CH_SP) begin
							if (esc != ESC_NONE) line_bad = 1'b1;
							esc = ESC_NONE;
							r.field_end = 1'b1;
							r.field_kind = KIND_URL;
							phase = PH_VER;
						end else if (esc == ESC_PCT) begin
							nib = hex_value(b);
							if (nib < 0) begin
								line_bad = 1'b1;
								esc = ESC_NONE;
							end else begin
								esc_hi = nib[3:0];
								esc = ESC_HI;
							end
						end else if (esc == ESC_HI) begin
							nib = hex_value(b);
							if (nib < 0) begin
								line_bad = 1'b1;
							end else begin
								r.byte_valid = 1'b1;
								r.out_byte = {esc_hi, nib[3:0]};
								r.field_kind = KIND_URL;
							end
							esc = ESC_NONE;
						end else if (b == CH_PCT) begin
							esc = ESC_PCT;
						end else begin
							r.byte_valid = 1'b1;
							r.out_byte = b;
							r.field_kind = KIND_URL;
						end
					end
					PH_VER: begin
						r.byte_valid = 1'b1;
						r.out_byte = b;
						r.field_kind = KIND_VER;
					end
					PH_HNAME: begin
						if (b == CH_COLON) begin
							r.field_end = 1'b1;
							r.field_kind = KIND_HNAME;
							phase = PH_HVAL;
							skip = 2;
						end else begin
							r.byte_valid = 1'b1;
							r.out_byte = b;
							r.field_kind = KIND_HNAME;
						end
					end
					default: begin
						// two bytes after the colon are dropped
						if (skip > 0) begin
							skip--;
						end else begin
							r.byte_valid = 1'b1;
							r.out_byte = b;
							r.field_kind = KIND_HVAL;
						end
					end
				endcase
			end
			r.verdict = verdict;
			fields_due.push_back(r);
		endfunction

		function void field_check(string name, logic [7:0] want, logic [7:0] got);
			if (got !== want) begin
				$display("%0t: %s expected %0h got %0h", $time, name, want, got);
				errors++;
			end
		endfunction

		function void check_word(head_out_t got);
			head_out_t want;
			if (fields_due.size() == 0) begin
				$display("%0t: result word %h with nothing expected", $time, got);
				errors++;
				return;
			end
			want = fields_due.pop_front();
			field_check("byte_valid", 8'(want.byte_valid), 8'(got.byte_valid));
			field_check("out_byte", want.out_byte, got.out_byte);
			field_check("field_kind", 8'(want.field_kind), 8'(got.field_kind));
			field_check("field_end", 8'(want.field_end), 8'(got.field_end));
			field_check("verdict", 8'(want.verdict), 8'(got.verdict));
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;    // [7:0] data_byte
	logic        s_tuser;    // [0] command
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;    // [0] byte_valid, [8:1] out_byte, [9] field_end, [12:10] verdict
	logic [2:0]  m_tuser;    // [2:0] field_kind
	logic        cfg_we;
	logic        cfg_index;
	logic [15:0] cfg_data;

	parse_scoreboard board = new();
	head_in_t        head_bytes_q[$];    // words waiting to be offered
	int              words_in = 0;
	int              idle_cycles = 0;

	string verb_pool[8] = '{"GET", "POST", "GE", "GETS", "POS", "POSTT", "PUT", "HEAD"};
	string hex_pool = "0123456789abcdefABCDEF";

	http_request_head_parser dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// both handshakes sampled at the rising edge; inputs move only at the falling edge
	always @(posedge clk) begin
		head_out_t seen;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				board.note_byte(s_tuser, s_tdata);
				words_in++;
			end
			if (m_tvalid && m_tready) begin
				seen.byte_valid = m_tdata[0];
				seen.out_byte = m_tdata[8:1];
				seen.field_end = m_tdata[9];
				seen.verdict = m_tdata[12:10];
				seen.field_kind = m_tuser;
				board.check_word(seen);
			end
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
			else idle_cycles++;
		end
	end

	// watchdog: nothing moved for too long
	initial begin
		wait (arst_n === 1'b1);
		while (idle_cycles < IdleLimit) @(posedge clk);
		$display("CHECKS FAILED");
		$finish;
	end

	// receiver: random stall patterns, plus two long hold-offs so the input backs up
	initial begin
		int mode;
		bit held_early;
		bit held_late;
		m_tready = 1'b0;
		held_early = 1'b0;
		held_late = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if ((!held_early && words_in >= 100) || (!held_late && words_in >= 700)) begin
				if (words_in >= 700) held_late = 1'b1;
				held_early = 1'b1;
				m_tready <= 1'b0;
				repeat (HoldCycles) @(negedge clk);
			end
			mode = $urandom_range(0, 3);
			repeat ($urandom_range(8, 60)) begin
				case (mode)
					0: m_tready <= 1'b1;
					1: m_tready <= 1'($urandom_range(0, 1));
					2: m_tready <= ($urandom_range(0, 9) != 0);
					default: m_tready <= ($urandom_range(0, 3) == 0);
				endcase
				@(negedge clk);
			end
		end
	end

	function automatic void push_word(input logic cmd, input logic [7:0] data);
		head_bytes_q.push_back('{command: cmd, data_byte: data});
	endfunction

	function automatic void push_crlf();
		push_word(CMD_BYTE, CH_CR);
		push_word(CMD_BYTE, CH_LF);
	endfunction

	function automatic void push_text(input string s, input bit mix_case = 1'b0);
		logic [7:0] c;
		for (int i = 0; i < s.len(); i++) begin
			c = s[i];
			if (mix_case && $urandom_range(0, 1) &&
			    ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A)))
				c = c ^ 8'h20;
			push_word(CMD_BYTE, c);
		end
	endfunction

	// mostly printable, sometimes any byte; never a carriage return
	function automatic logic [7:0] rand_char(input bit no_space, input bit no_colon,
	                                         input bit no_pct);
		logic [7:0] c;
		do
			c = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(33, 126)) : 8'($urandom);
		while (c == CH_CR || (no_space && c == CH_SP) || (no_colon && c == CH_COLON) ||
		       (no_pct && c == CH_PCT));
		return c;
	endfunction

	function automatic logic [7:0] bad_hex_char();
		logic [7:0] c;
		do
			c = rand_char(1'b1, 1'b0, 1'b0);
		while (parse_scoreboard::hex_value(c) >= 0);
		return c;
	endfunction

	function automatic logic [7:0] hex_char();
		return hex_pool[$urandom_range(0, 21)];
	endfunction

	// one request head with random content; about a fifth carry a defect
	function automatic void push_request();
		int flaw;
		int pick;
		int n_hdr;
		logic [7:0] b;
		flaw = ($urandom_range(0, 99) < 78) ? 0 : $urandom_range(1, 6);
		push_word(CMD_START, 8'($urandom));
		// garbage then a restart in the middle of it
		if (flaw == 6) begin
			repeat ($urandom_range(3, 12)) push_word(CMD_BYTE, 8'($urandom));
			push_word(CMD_START, 8'($urandom));
		end

		// method
		if ($urandom_range(0, 6) == 0)
			repeat ($urandom_range(0, 5)) push_word(CMD_BYTE, rand_char(1'b1, 1'b0, 1'b0));
		else
			push_text(verb_pool[$urandom_range(0, 7)], 1'($urandom_range(0, 1)));
		push_word(CMD_BYTE, CH_SP);

		// url with good and broken escapes
		repeat ($urandom_range(0, 8)) begin
			pick = $urandom_range(0, 99);
			if (pick < 65) begin
				push_word(CMD_BYTE, rand_char(1'b1, 1'b0, 1'b1));
			end else begin
				push_word(CMD_BYTE, CH_PCT);
				if (pick < 85) begin
					push_word(CMD_BYTE, hex_char());
					push_word(CMD_BYTE, hex_char());
				end else if (pick < 92) begin
					push_word(CMD_BYTE, bad_hex_char());
				end else begin
					push_word(CMD_BYTE, hex_char());
					push_word(CMD_BYTE, bad_hex_char());
				end
			end
		end
		// escape cut short by the closing space
		if ($urandom_range(0, 19) == 0) begin
			push_word(CMD_BYTE, CH_PCT);
			if ($urandom_range(0, 1)) push_word(CMD_BYTE, hex_char());
		end
		if (flaw != 2) push_word(CMD_BYTE, CH_SP);

		// version
		if ($urandom_range(0, 9) < 7)
			push_text("HTTP/1.1");
		else
			repeat ($urandom_range(0, 8)) push_word(CMD_BYTE, rand_char(1'b0, 1'b0, 1'b0));
		if (flaw == 1) begin
			// carriage return with no line feed after it
			push_word(CMD_BYTE, CH_CR);
			do b = 8'($urandom); while (b == CH_LF);
			push_word(CMD_BYTE, b);
		end else begin
			push_crlf();
		end

		// header lines
		n_hdr = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 9) : $urandom_range(0, 3);
		repeat (n_hdr) begin
			repeat ($urandom_range(0, 6)) push_word(CMD_BYTE, rand_char(1'b0, 1'b1, 1'b0));
			if (flaw != 3) push_word(CMD_BYTE, CH_COLON);
			repeat (($urandom_range(0, 2) == 0) ? $urandom_range(0, 2) : $urandom_range(2, 10))
				push_word(CMD_BYTE, rand_char(1'b0, 1'b0, 1'b0));
			if (flaw == 4) push_word(CMD_BYTE, CH_LF);
			if (flaw == 5)
				repeat ($urandom_range(20, 70)) push_word(CMD_BYTE, rand_char(1'b0, 1'b0, 1'b0));
			push_crlf();
		end
		push_crlf();

		// stray bytes after the verdict
		if ($urandom_range(0, 4) == 0)
			repeat ($urandom_range(1, 6)) push_word(CMD_BYTE, 8'($urandom));
	endfunction

	task automatic send_word(input head_in_t w);
		s_tvalid <= 1'b1;
		s_tuser <= w.command;
		s_tdata <= w.data_byte;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	// sender: bursts of random length with random gaps, some long gap-free runs
	task automatic drive_words();
		int burst;
		int gap;
		while (head_bytes_q.size() != 0) begin
			if ($urandom_range(0, 3) == 0) begin
				burst = $urandom_range(20, 80);
				gap = 0;
			end else begin
				burst = $urandom_range(1, 12);
				gap = $urandom_range(0, 7);
			end
			while (burst > 0 && head_bytes_q.size() != 0) begin
				send_word(head_bytes_q.pop_front());
				burst--;
			end
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		s_tvalid <= 1'b0;
	endtask

	// every word yields a result, so an empty queue means the block is idle
	task automatic wait_drained();
		while (board.fields_due.size() != 0) @(negedge clk);
	endtask

	task automatic write_regs(input logic [15:0] line_limit, input logic [7:0] header_limit);
		cfg_we <= 1'b1;
		cfg_index <= CFG_MAX_LINE;
		cfg_data <= line_limit;
		@(negedge clk);
		cfg_index <= CFG_MAX_HDR;
		cfg_data <= {8'h00, header_limit};
		@(negedge clk);
		cfg_we <= 1'b0;
		board.write_reg(CFG_MAX_LINE, line_limit);
		board.write_reg(CFG_MAX_HDR, {8'h00, header_limit});
	endtask

	task automatic run_phase(input logic [15:0] line_limit, input logic [7:0] header_limit,
	                         input int budget);
		write_regs(line_limit, header_limit);
		while (head_bytes_q.size() < budget) push_request();
		drive_words();
		wait_drained();
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = CMD_BYTE;
		cfg_we = 1'b0;
		cfg_index = CFG_MAX_LINE;
		cfg_data = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed part: tiny line buffer and no header lines allowed
		write_regs(16'd6, 8'd0);
		// carriage return with no line feed, then bytes after the verdict
		push_word(CMD_START, 8'hFF);
		push_word(CMD_BYTE, CH_CR);
		push_word(CMD_BYTE, 8'hFF);
		push_word(CMD_BYTE, 8'h00);
		// request line without its spaces
		push_word(CMD_START, 8'h00);
		push_text("a");
		push_crlf();
		// broken escape in the url shows up at line end
		push_word(CMD_START, 8'h5A);
		push_text("P %G ");
		push_crlf();
		// empty fields, header with empty name and empty value, over the header count
		push_word(CMD_START, 8'hA5);
		push_text("  ");
		push_crlf();
		push_text(":");
		push_crlf();
		push_crlf();
		// line longer than the buffer
		push_word(CMD_START, 8'h01);
		push_text("abcdef");
		drive_words();
		wait_drained();

		// random part; the sender waits for every result at each boundary
		run_phase(MAX_LINE_RST, MAX_HDR_RST, 190);
		run_phase(16'd65535, 8'd255, 190);
		run_phase(16'd16, 8'd2, 160);
		run_phase(16'd2, 8'd0, 50);
		run_phase(16'd40, 8'd0, 110);
		repeat (2)
			run_phase(16'($urandom_range(0, 1) ? $urandom_range(2, 64)
			                                   : $urandom_range(2, 65535)),
			          8'($urandom_range(0, 1) ? $urandom_range(0, 4) : $urandom_range(0, 255)),
			          100);

		// let any stray result surface
		repeat (6) @(posedge clk);
		if (board.errors == 0 && board.fields_due.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

[files.f]
+incdir+hdl
hdl/hrhp_pkg.sv
hdl/http_request_head_parser.sv
hdl/hrhp_checker.sv
tb/sv/tb.sv
